[hw/rtl/slmc_pkg.sv]
// shared types and constants for the set-associative lru miss counter
package slmc_pkg;

    localparam int ADDR_W           = 48;
    localparam int LINE_SIZE_BYTES  = 64;
    localparam int LINE_OFFSET_BITS = $clog2(LINE_SIZE_BYTES);
    localparam int LINE_W           = ADDR_W - LINE_OFFSET_BITS;
    localparam int SET_OUT_W        = 4;
    localparam int COUNT_W          = 32;
    localparam int CFG_W            = 5;
    localparam int CFG_IDX_W        = 1;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_SET_INDEX_BITS = 1'd0;
    localparam cfg_idx_t REG_WAYS_IN_USE    = 1'd1;

    typedef struct packed {
        logic [ADDR_W-1:0] byte_address;
        logic              last_access;
    } in_t;

    typedef struct packed {
        logic                 was_hit;
        logic [SET_OUT_W-1:0] set_number;
        logic [COUNT_W-1:0]   misses_so_far;
        logic                 trace_done;
    } out_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic lookup;
        logic commit;
    } cmd_t;

endpackage

[hw/rtl/slmc_ctrl.sv]
// controller state machine: request sequencing and output handshake
module slmc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output slmc_pkg::cmd_t cmd
);
    import slmc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hw/rtl/slmc_datapath.sv]
// datapath: set row memory, tag compare, lru reorder, fill levels and miss count
module slmc_datapath #(
    parameter int MAX_SET_COUNT = 16,
    parameter int MAX_WAY_COUNT = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  slmc_pkg::cmd_t            cmd,
    input  slmc_pkg::in_t             in_data,
    input  logic                      cfg_we,
    input  slmc_pkg::cfg_idx_t        cfg_index,
    input  logic [slmc_pkg::CFG_W-1:0] cfg_data,
    output slmc_pkg::out_t            out_data
);
    import slmc_pkg::*;

    localparam int SET_BITS_RAW = $clog2(MAX_SET_COUNT + 1) - 1;
    localparam int SET_BITS     = (SET_BITS_RAW > 7) ? 7 : SET_BITS_RAW;
    localparam int SIDX_W       = (SET_BITS < 1) ? 1 : SET_BITS;
    localparam int SET_DEPTH    = 2 ** SIDX_W;
    localparam int WAYS         = MAX_WAY_COUNT;
    localparam int WIDX_W       = (WAYS < 2) ? 1 : $clog2(WAYS);
    localparam int FILL_W       = $clog2(WAYS + 1);

    typedef logic [WAYS-1:0][LINE_W-1:0] row_t;

    // configuration
    logic [2:0]       sib_reg;
    logic [CFG_W-1:0] ways_reg;

    // set row memory, undefined until written
    row_t mem [SET_DEPTH];

    logic [FILL_W-1:0] fill_reg [SET_DEPTH];
    logic [COUNT_W-1:0] miss_reg;

    logic [LINE_W-1:0] line_reg;
    logic [SIDX_W-1:0] set_reg;
    logic              last_reg;
    row_t              row_reg;
    logic              hit_reg;
    logic              grow_reg;
    logic [WIDX_W-1:0] p_reg;
    logic [WIDX_W-1:0] e_reg;
    out_t              out_reg;

    logic [LINE_W-1:0] line_in;
    logic [2:0]        sib_eff;
    logic [SIDX_W-1:0] set_mask;
    logic [SIDX_W-1:0] set_in;
    logic [FILL_W-1:0] fill_cur;
    logic [5:0]        ways_eff;
    logic [WAYS-1:0]   match;
    logic              hit;
    logic [WIDX_W-1:0] found;
    logic              full;
    logic [WIDX_W-1:0] fill_m1;
    logic [WIDX_W-1:0] p_next;
    logic [WIDX_W-1:0] e_next;
    row_t              row_shift;
    row_t              row_new;
    logic [COUNT_W-1:0] miss_next;
    logic [7:0]        set_wide;

    assign line_in = in_data.byte_address[ADDR_W-1:LINE_OFFSET_BITS];
    assign sib_eff = (sib_reg > 3'(SET_BITS)) ? 3'(SET_BITS) : sib_reg;

    always_comb
    begin
        for (int i = 0; i < SIDX_W; i++)
        begin
            set_mask[i] = (3'(i) < sib_eff);
        end
    end

    assign set_in   = line_in[SIDX_W-1:0] & set_mask;
    assign fill_cur = fill_reg[set_reg];

    // zero ways acts as one, clamp to storage
    always_comb
    begin
        ways_eff = {1'b0, ways_reg};
        if (ways_eff == 6'd0)
        begin
            ways_eff = 6'd1;
        end
        if (ways_eff > 6'(WAYS))
        begin
            ways_eff = 6'(WAYS);
        end
    end

    // parallel tag compare over resident slots
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            match[w] = (row_reg[w] == line_reg) && (FILL_W'(w) < fill_cur);
        end
    end

    // lowest matching slot
    always_comb
    begin
        hit   = 1'b0;
        found = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit   = 1'b1;
                found = WIDX_W'(w);
            end
        end
    end

    assign full    = (6'(fill_cur) >= ways_eff);
    assign fill_m1 = WIDX_W'(fill_cur - FILL_W'(1));

    // shift window [p, e): slots move down one, new line lands in e
    always_comb
    begin
        if (hit)
        begin
            p_next = found;
            e_next = fill_m1;
        end
        else if (full)
        begin
            p_next = '0;
            e_next = fill_m1;
        end
        else
        begin
            p_next = WIDX_W'(fill_cur);
            e_next = WIDX_W'(fill_cur);
        end
    end

    assign row_shift = row_reg >> LINE_W;

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            if (WIDX_W'(w) == e_reg)
            begin
                row_new[w] = line_reg;
            end
            else if ((WIDX_W'(w) >= p_reg) && (WIDX_W'(w) < e_reg))
            begin
                row_new[w] = row_shift[w];
            end
            else
            begin
                row_new[w] = row_reg[w];
            end
        end
    end

    always_comb
    begin
        miss_next = miss_reg;
        if (!hit_reg && (miss_reg != '1))
        begin
            miss_next = miss_reg + COUNT_W'(1);
        end
    end

    assign set_wide = 8'(set_reg);
    assign out_data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sib_reg  <= '0;
            ways_reg <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SET_INDEX_BITS: sib_reg  <= cfg_data[2:0];
                REG_WAYS_IN_USE:    ways_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            miss_reg <= '0;
            for (int s = 0; s < SET_DEPTH; s++)
            begin
                fill_reg[s] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            if (last_reg)
            begin
                miss_reg <= '0;
                for (int s = 0; s < SET_DEPTH; s++)
                begin
                    fill_reg[s] <= '0;
                end
            end
            else
            begin
                miss_reg <= miss_next;
                if (grow_reg)
                begin
                    fill_reg[set_reg] <= fill_cur + FILL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            line_reg <= line_in;
            set_reg  <= set_in;
            last_reg <= in_data.last_access;
            row_reg  <= mem[set_in];
        end
        if (cmd.lookup)
        begin
            hit_reg  <= hit;
            grow_reg <= !hit && !full;
            p_reg    <= p_next;
            e_reg    <= e_next;
        end
        if (cmd.commit)
        begin
            mem[set_reg]          <= row_new;
            out_reg.was_hit       <= hit_reg;
            out_reg.set_number    <= set_wide[SET_OUT_W-1:0];
            out_reg.misses_so_far <= miss_next;
            out_reg.trace_done    <= last_reg;
        end
    end

endmodule

[hw/rtl/set_assoc_lru_miss_counter_top.sv]
// top level of the set-associative lru miss counter
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------
//   in      | input     | in_valid / in_ready | in_data: byte_address, last_access
//   out     | output    | out_valid/out_ready | out_data: was_hit, set_number,
//           |           |                     |   misses_so_far, trace_done
//   cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// each request runs through set row read, tag compare and lru row write-back
// a new request is taken no earlier than the cycle after the previous row write,
//   so requests never overlap and each row read sees the last write-back
// the result register frees the input side: a request is taken while a result waits,
//   and only the write-back step stalls while a result waits and out_ready is low
// reset clears fill levels, miss count, set bits; ways go to one; rows stay unset
module set_assoc_lru_miss_counter_top #(
    parameter int MAX_SET_COUNT = 16,
    parameter int MAX_WAY_COUNT = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  slmc_pkg::in_t               in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output slmc_pkg::out_t              out_data,
    input  logic                        cfg_we,
    input  slmc_pkg::cfg_idx_t          cfg_index,
    input  logic [slmc_pkg::CFG_W-1:0]  cfg_data
);
    import slmc_pkg::*;

    // command bundle from controller to datapath
    cmd_t cmd;

    // sequencer: accept, lookup, commit with output handshake
    slmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // row memory, compare, lru reorder, counters and result register
    slmc_datapath #(
        .MAX_SET_COUNT (MAX_SET_COUNT),
        .MAX_WAY_COUNT (MAX_WAY_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

endmodule

[bench/tb_top.sv]
// self-checking testbench for the set-associative lru miss counter top level
`timescale 1ns / 100ps

module tb_top;

    import slmc_pkg::*;

    localparam int SET_LIMIT     = 16;
    localparam int WAY_LIMIT     = 16;
    localparam int RESET_CYCLES  = 9;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 115;
    localparam int POOL_DEPTH    = 64;
    localparam int MAX_REPORTS   = 40;
    localparam int LIMIT_CYCLES  = 400000;

    // cache model: shadow copy of the sets, fill levels, miss count and registers;
    // every accepted request produces exactly one expected result
    class lru_cache_model;
        out_t              expected_results[$];
        int                errors;
        int                reports;
        logic [2:0]        set_bits;
        logic [4:0]        ways_cfg;
        logic [LINE_W-1:0] lines [SET_LIMIT][WAY_LIMIT];
        int                fill_level [SET_LIMIT];
        logic [COUNT_W-1:0] miss_count;

        function new();
            errors   = 0;
            reports  = 0;
            set_bits = 3'd0;
            ways_cfg = 5'd1;
            clear_trace();
        endfunction

        function void clear_trace();
            foreach (fill_level[i])
                fill_level[i] = 0;
            miss_count = '0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_SET_INDEX_BITS: set_bits = value[2:0];
                REG_WAYS_IN_USE:    ways_cfg = value[4:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_request(in_t req);
            logic [LINE_W-1:0] line;
            out_t              res;
            int                bits;
            int                sets;
            int                ways;
            int                set_sel;
            int                fill;
            int                hit_way;

            line = req.byte_address[ADDR_W-1:LINE_OFFSET_BITS];
            // too many sets falls back to the largest power of two that fits
            bits = set_bits;
            while (bits > 0 && (1 << bits) > SET_LIMIT)
                bits--;
            sets = 1 << bits;
            // zero ways acts as one, too many ways is clamped
            ways = (ways_cfg == 0) ? 1 : ((ways_cfg > WAY_LIMIT) ? WAY_LIMIT : ways_cfg);
            set_sel = int'(line[3:0]) & (sets - 1);
            fill = fill_level[set_sel];

            hit_way = -1;
            for (int w = 0; w < fill; w++)
                if (hit_way < 0 && lines[set_sel][w] == line)
                    hit_way = w;

            if (hit_way < 0 && miss_count != '1)
                miss_count++;

            if (hit_way >= 0 || fill >= ways)
            begin
                // hit moves the line to the mru end; a full set drops the lru line,
                // and a set above the lowered way count keeps its fill level
                for (int w = (hit_way >= 0) ? hit_way : 0; w + 1 < fill; w++)
                    lines[set_sel][w] = lines[set_sel][w + 1];
                lines[set_sel][fill - 1] = line;
            end
            else
            begin
                lines[set_sel][fill] = line;
                fill_level[set_sel] = fill + 1;
            end

            res.was_hit       = (hit_way >= 0);
            res.set_number    = 4'(set_sel);
            res.misses_so_far = miss_count;
            res.trace_done    = req.last_access;
            expected_results.push_back(res);

            if (req.last_access)
                clear_trace();
        endfunction

        function void compare_field(string field, logic [COUNT_W-1:0] want,
                                    logic [COUNT_W-1:0] got);
            if (want !== got)
            begin
                errors++;
                if (reports < MAX_REPORTS)
                begin
                    reports++;
                    $display("%0t: %s mismatch, expected %0h, actual %0h",
                             $time, field, want, got);
                end
            end
        endfunction

        function void check_result(out_t got);
            out_t want;

            if (expected_results.size() == 0)
            begin
                errors++;
                if (reports < MAX_REPORTS)
                begin
                    reports++;
                    $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                end
                return;
            end
            want = expected_results.pop_front();
            compare_field("was_hit", want.was_hit, got.was_hit);
            compare_field("set_number", want.set_number, got.set_number);
            compare_field("misses_so_far", want.misses_so_far, got.misses_so_far);
            compare_field("trace_done", want.trace_done, got.trace_done);
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    in_t              in_data;
    logic             out_valid;
    logic             out_ready;
    out_t             out_data;
    logic             cfg_we;
    cfg_idx_t         cfg_index;
    logic [CFG_W-1:0] cfg_data;

    lru_cache_model   cache_model;

    // idle percentages of the request and result sides
    int send_idle_pct;
    int recv_idle_pct;
    // set by the main sequence to make the result side hold off for a long stretch
    bit hold_off_req;
    int cycle_count;

    // working set of line numbers; most random requests reuse these to get hits
    logic [LINE_W-1:0] line_pool [POOL_DEPTH];
    int                pool_size;

    // register settings per random phase; covers the clamp cases and lowered ways
    int phase_sets [PHASE_COUNT] = '{4, 7, 2, 3, 1, 5, 4, 0};
    int phase_ways [PHASE_COUNT] = '{16, 31, 0, 4, 2, 17, 3, 8};

    set_assoc_lru_miss_counter_top #(
        .MAX_SET_COUNT (SET_LIMIT),
        .MAX_WAY_COUNT (WAY_LIMIT)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: ready changes on the falling edge, with an optional long hold-off
    // so the pipeline and result register back up into the request side
    initial
    begin
        int hold_left;

        hold_left = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // results are sampled at the rising edge, where the handshake completes
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            cache_model.check_result(out_data);

    // watchdog: a lost result or a stuck handshake ends the run here
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("set_assoc_lru_miss_counter_top verification failed");
        $finish;
    end

    // offer one request from a falling edge and hold it until accepted;
    // returns on the falling edge after acceptance so the caller drives next
    task automatic send_request(input in_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        cache_model.note_request(req);
        @(negedge clk);
    endtask

    task automatic send_addr(input logic [ADDR_W-1:0] addr, input logic last);
        in_t req;

        req.byte_address = addr;
        req.last_access  = last;
        send_request(req);
    endtask

    // registers only change with nothing in flight; the extra cycles are margin
    // after the last result
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (cache_model.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // one write cycle, then cfg_we drops again before the next write
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cache_model.write_reg(idx, value);
        @(negedge clk);
    endtask

    function automatic in_t make_request();
        in_t               req;
        int                pick;
        logic [LINE_W-1:0] line;
        logic [63:0]       wide;

        pick = $urandom_range(99);
        wide = {$urandom(), $urandom()};
        if (pick < 8)
            req.byte_address = wide[ADDR_W-1:0];
        else
        begin
            line = line_pool[$urandom_range(pool_size - 1)];
            // near miss: one line bit flipped, often the same set with another tag
            if (pick < 14)
                line = line ^ (LINE_W'(1) << $urandom_range(LINE_W - 1));
            req.byte_address = {line, wide[LINE_OFFSET_BITS-1:0]};
        end
        req.last_access = ($urandom_range(59) == 0);
        return req;
    endfunction

    initial
    begin
        logic [63:0] wide;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_SET_INDEX_BITS;
        cfg_data      = '0;
        send_idle_pct = 33;
        recv_idle_pct = 61;
        hold_off_req  = 1'b0;
        pool_size     = 1;
        cache_model   = new();

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: one set, one way, so every new line evicts the old one;
        // offsets within a line hit, address extremes, and a trace end that clears
        send_addr(48'h0000_0000_0000, 1'b0);
        send_addr(48'h0000_0000_003F, 1'b0);
        send_addr(48'h0000_0000_0040, 1'b0);
        send_addr(48'h0000_0000_0000, 1'b0);
        send_addr(48'hFFFF_FFFF_FFFF, 1'b0);
        send_addr(48'hFFFF_FFFF_FFC0, 1'b0);
        send_addr(48'h0000_0000_0000, 1'b1);
        send_addr(48'h0000_0000_0000, 1'b0);

        // two sets, two ways: lru order decides which line is evicted
        wait_drain();
        write_reg(REG_SET_INDEX_BITS, 5'd1);
        write_reg(REG_WAYS_IN_USE, 5'd2);
        send_addr(48'h0000_0000_0000, 1'b0);
        send_addr(48'h0000_0000_0080, 1'b0);
        send_addr(48'h0000_0000_0040, 1'b0);
        send_addr(48'h0000_0000_0000, 1'b0);
        send_addr(48'h0000_0000_0100, 1'b0);
        send_addr(48'h0000_0000_0080, 1'b0);
        send_addr(48'h0000_0000_0004, 1'b0);

        // fill set zero to four ways, then lower the way count under it
        wait_drain();
        write_reg(REG_WAYS_IN_USE, 5'd4);
        send_addr(48'h0000_0000_0180, 1'b0);
        send_addr(48'h0000_0000_0200, 1'b0);
        wait_drain();
        write_reg(REG_WAYS_IN_USE, 5'd2);
        send_addr(48'h0000_0000_0280, 1'b0);
        send_addr(48'h0000_0000_0200, 1'b0);
        send_addr(48'h7FFF_FFFF_FFC0, 1'b1);

        // random phases: traces run on across register changes unless a trace end
        // happens to fall at a phase boundary
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            wait_drain();
            write_reg(REG_SET_INDEX_BITS, CFG_W'(phase_sets[p]));
            write_reg(REG_WAYS_IN_USE, CFG_W'(phase_ways[p]));

            if (p < 3)
            begin
                send_idle_pct = 33;
                recv_idle_pct = 61;
            end
            else if (p < 6)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 33;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 1 || p == 4)
                hold_off_req = 1'b1;

            // small pools give mostly hits, large ones push evictions
            pool_size = $urandom_range(3, 48);
            for (int i = 0; i < pool_size; i++)
            begin
                wide = {$urandom(), $urandom()};
                line_pool[i] = wide[LINE_W-1:0];
            end

            repeat (PHASE_ITEMS) send_request(make_request());
        end

        wait_drain();
        if (cache_model.errors == 0)
            $display("set_assoc_lru_miss_counter_top verification clean");
        else
            $display("set_assoc_lru_miss_counter_top verification failed");
        $finish;
    end

endmodule
